// ===== rtl/core/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, register indexes, phase codes and constants of the deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_FRAME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_FRAME = 1'd1;

  // Register reset values.
  localparam logic [31:0] MAX_FRAME_RST = 32'd65536;
  localparam logic [7:0]  MIN_FRAME_RST = 8'd20;

  // Parse phases.
  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_FIRST   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SECOND  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_EXTLEN  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_KEY     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

  // Length codes in the second header byte.
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Extended length byte counts and header sizes.
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [3:0] HDR_BASE     = 4'd2;
  localparam logic [3:0] HDR_EXT16    = 4'd4;
  localparam logic [3:0] HDR_EXT64    = 4'd10;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  // Result kinds and error codes.
  localparam logic KIND_PAYLOAD  = 1'b0;
  localparam logic KIND_ERROR    = 1'b1;
  localparam logic ERR_TOO_SMALL = 1'b0;
  localparam logic ERR_TOO_LARGE = 1'b1;

  // Frame size limits as seen by the parser.
  typedef struct packed {
    logic [31:0] max_frame_size;
    logic [7:0]  min_frame_size;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        last_in_frame;
    logic [31:0] data_len;
    logic        error_code;
  } res_t;

endpackage

// ===== rtl/core/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received frame headers, checks the whole frame size against the
// configured limits and emits unmasked payload bytes or one error word.
// ----------------------------------------------------------------------------
// Each byte passes the input register; its result word, if any, is held in the result register.
// Throughput: one byte per cycle while the result register is free or being read;
// an unread result word holds the input register and stalls the stream.
// Reset: parse state and valid flags clear at once; limits return to their
// defaults. After a frame error every byte is dropped until reset.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Byte stream in.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            stream_byte_i,
  // Result words out.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  kind_o,
  output logic [7:0]            payload_byte_o,
  output logic                  last_in_frame_o,
  output logic [31:0]           data_len_o,
  output logic                  error_code_o
);

  cfg_t       cfg;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       res_valid;
  res_t       res;
  logic       out_vld_q;
  res_t       out_res_q;

  wsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held byte moves on when the result register is free or being read.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= stream_byte_i;
    end
  end

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_valid;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign kind_o           = out_res_q.kind;
  assign payload_byte_o   = out_res_q.payload_byte;
  assign last_in_frame_o  = out_res_q.last_in_frame;
  assign data_len_o       = out_res_q.data_len;
  assign error_code_o     = out_res_q.error_code;

endmodule

// ===== rtl/core/wsd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer configuration registers
// Holds the frame size limits, written through a plain write port.
// ----------------------------------------------------------------------------
module wsd_cfg_regs import wsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  logic [31:0] max_frame_q;
  logic [7:0]  min_frame_q;

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= MAX_FRAME_RST;
      min_frame_q <= MIN_FRAME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_MAX_FRAME: max_frame_q <= cfg_wdata_i[31:0];
        CFG_IDX_MIN_FRAME: min_frame_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.max_frame_size = max_frame_q;
  assign cfg_o.min_frame_size = min_frame_q;

endmodule

// ===== rtl/core/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Holds the parse state, steps it by one byte when told to and forms the
// result word for payload bytes and frame errors.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [3:0]         hdr_left_q, hdr_left_d;
  logic [63:0]        len_acc_q, len_acc_d;
  logic [31:0]        pay_left_q, pay_left_d;
  logic               masked_q, masked_d;
  logic [31:0]        key_q, key_d;
  logic [1:0]         key_idx_q, key_idx_d;
  logic               halted_q, halted_d;
  logic [3:0]         hdr_size_q, hdr_size_d;

  logic               do_check;
  logic               too_small;
  logic               too_large;
  logic [8:0]         small_sum;
  logic [32:0]        large_sum;
  logic [7:0]         key_byte;

  // Next state and result for one byte.
  always_comb begin
    phase_d     = phase_q;
    hdr_left_d  = hdr_left_q;
    len_acc_d   = len_acc_q;
    pay_left_d  = pay_left_q;
    masked_d    = masked_q;
    key_d       = key_q;
    key_idx_d   = key_idx_q;
    halted_d    = halted_q;
    hdr_size_d  = hdr_size_q;
    do_check    = 1'b0;
    key_byte    = 8'd0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i && !halted_q) begin
      case (phase_q)
        PH_FIRST: begin
          phase_d = PH_SECOND;
        end
        PH_SECOND: begin
          masked_d = byte_i[7];
          key_d    = 32'd0;
          if (byte_i[6:0] == LEN_CODE_EXT16) begin
            hdr_left_d = EXT16_BYTES;
            hdr_size_d = HDR_EXT16;
            len_acc_d  = 64'd0;
          end else if (byte_i[6:0] == LEN_CODE_EXT64) begin
            hdr_left_d = EXT64_BYTES;
            hdr_size_d = HDR_EXT64;
            len_acc_d  = 64'd0;
          end else begin
            hdr_left_d = 4'd0;
            hdr_size_d = HDR_BASE;
            len_acc_d  = {57'd0, byte_i[6:0]};
          end
          if (byte_i[7]) begin
            hdr_size_d = hdr_size_d + KEY_BYTES;
          end
          if (hdr_left_d != 4'd0) begin
            phase_d = PH_EXTLEN;
          end else begin
            do_check = 1'b1;
          end
        end
        PH_EXTLEN: begin
          len_acc_d  = {len_acc_q[55:0], byte_i};
          hdr_left_d = hdr_left_q - 4'd1;
          if (hdr_left_d == 4'd0) begin
            do_check = 1'b1;
          end
        end
        PH_KEY: begin
          key_d      = {key_q[23:0], byte_i};
          hdr_left_d = hdr_left_q - 4'd1;
          if (hdr_left_d == 4'd0) begin
            phase_d = (pay_left_q != 32'd0) ? PH_PAYLOAD : PH_FIRST;
          end
        end
        PH_PAYLOAD: begin
          if (masked_q) begin
            case (key_idx_q)
              2'd0:    key_byte = key_q[31:24];
              2'd1:    key_byte = key_q[23:16];
              2'd2:    key_byte = key_q[15:8];
              default: key_byte = key_q[7:0];
            endcase
          end
          key_idx_d  = key_idx_q + 2'd1;
          pay_left_d = pay_left_q - 32'd1;
          res_valid_o          = 1'b1;
          res_o.kind           = KIND_PAYLOAD;
          res_o.payload_byte   = byte_i ^ key_byte;
          res_o.last_in_frame  = (pay_left_d == 32'd0);
          res_o.data_len       = len_acc_q[31:0];
          res_o.error_code     = ERR_TOO_SMALL;
          if (pay_left_d == 32'd0) begin
            phase_d = PH_FIRST;
          end
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase
    end

    // Whole frame size check once the length is complete.
    small_sum = {1'b0, len_acc_d[7:0]} + {5'd0, hdr_size_d};
    large_sum = {1'b0, len_acc_d[31:0]} + {29'd0, hdr_size_d};
    too_small = (len_acc_d[63:8] == 56'd0) && (small_sum < {1'b0, cfg_i.min_frame_size});
    too_large = (len_acc_d[63:32] != 32'd0) || (large_sum > {1'b0, cfg_i.max_frame_size});

    if (do_check) begin
      if (too_small || too_large) begin
        halted_d             = 1'b1;
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_ERROR;
        res_o.payload_byte   = 8'd0;
        res_o.last_in_frame  = 1'b0;
        res_o.data_len       = len_acc_d[31:0];
        res_o.error_code     = too_small ? ERR_TOO_SMALL : ERR_TOO_LARGE;
      end else begin
        pay_left_d = len_acc_d[31:0];
        key_idx_d  = 2'd0;
        if (masked_d) begin
          phase_d    = PH_KEY;
          hdr_left_d = KEY_BYTES;
        end else begin
          phase_d = (pay_left_d != 32'd0) ? PH_PAYLOAD : PH_FIRST;
        end
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FIRST;
      hdr_left_q <= 4'd0;
      len_acc_q  <= 64'd0;
      pay_left_q <= 32'd0;
      masked_q   <= 1'b0;
      key_q      <= 32'd0;
      key_idx_q  <= 2'd0;
      halted_q   <= 1'b0;
      hdr_size_q <= 4'd0;
    end else begin
      phase_q    <= phase_d;
      hdr_left_q <= hdr_left_d;
      len_acc_q  <= len_acc_d;
      pay_left_q <= pay_left_d;
      masked_q   <= masked_d;
      key_q      <= key_d;
      key_idx_q  <= key_idx_d;
      halted_q   <= halted_d;
      hdr_size_q <= hdr_size_d;
    end
  end

endmodule
